/* rtl/core/gbr_pkg.sv */
// Shared types and constants for the rotated glyph blitter.
package gbr_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  localparam logic       CFG_SEAM_X   = 1'b0;
  localparam logic       CFG_SEAM_GAP = 1'b1;

  localparam logic [9:0] SEAM_X_RST   = 10'd396;
  localparam logic [5:0] SEAM_GAP_RST = 6'd8;

  localparam int         FONT_ADDR_W  = 13;
  localparam logic [7:0] WHITE_BYTE   = 8'hFF;
  localparam logic [7:0] MSB_MASK     = 8'h80;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clr_step;
    logic red_step;
    logic font_wr;
    logic draw_init;
    logic font_rd;
    logic pix_load;
    logic pix_map;
    logic pix_mirror;
    logic pix_addr;
    logic fb_rd;
    logic fb_wr;
    logic advance;
    logic resp_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic clr_last;
    logic red_last;
    logic draw_empty;
    logic bit_set;
    logic pix_ok;
    logic draw_last;
    logic byte_next;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/gbr_ctrl.sv */
// Command sequencer for the glyph blitter: clear sweep, font load, draw walk, read.
module gbr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gbr_pkg::sts_t sts_i,
  output gbr_pkg::ctl_t ctl_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_REDUCE,
    S_LOAD,
    S_DINIT,
    S_FETCH,
    S_TEST,
    S_MAP,
    S_MIRROR,
    S_ADDR,
    S_FBRD,
    S_FBWR,
    S_NEXT,
    S_RDFB,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   clr_resp_q, clr_resp_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    clr_resp_d = clr_resp_q;
    ctl_o      = '0;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = clr_resp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd)
          gbr_pkg::CMD_LOAD, gbr_pkg::CMD_DRAW: state_d = S_REDUCE;
          gbr_pkg::CMD_CLEAR: begin
            clr_resp_d = 1'b1;
            state_d    = S_CLEAR;
          end
          default: state_d = S_RDFB;
        endcase
      end
      S_REDUCE: begin
        ctl_o.red_step = 1'b1;
        if (sts_i.red_last) begin
          state_d = (sts_i.cmd == gbr_pkg::CMD_LOAD) ? S_LOAD : S_DINIT;
        end
      end
      S_LOAD: begin
        ctl_o.font_wr = 1'b1;
        state_d       = S_RESP;
      end
      S_DINIT: begin
        ctl_o.draw_init = 1'b1;
        state_d         = sts_i.draw_empty ? S_RESP : S_FETCH;
      end
      S_FETCH: begin
        ctl_o.font_rd = 1'b1;
        state_d       = S_TEST;
      end
      S_TEST: begin
        if (sts_i.bit_set) begin
          ctl_o.pix_load = 1'b1;
          state_d        = S_MAP;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_MAP: begin
        ctl_o.pix_map = 1'b1;
        state_d       = S_MIRROR;
      end
      S_MIRROR: begin
        ctl_o.pix_mirror = 1'b1;
        state_d          = S_ADDR;
      end
      S_ADDR: begin
        ctl_o.pix_addr = 1'b1;
        state_d        = sts_i.pix_ok ? S_FBRD : S_NEXT;
      end
      S_FBRD: begin
        ctl_o.fb_rd = 1'b1;
        state_d     = S_FBWR;
      end
      S_FBWR: begin
        ctl_o.fb_wr = 1'b1;
        state_d     = S_NEXT;
      end
      S_NEXT: begin
        if (sts_i.draw_last) begin
          state_d = S_RESP;
        end else begin
          ctl_o.advance = 1'b1;
          state_d       = sts_i.byte_next ? S_FETCH : S_TEST;
        end
      end
      S_RDFB: begin
        ctl_o.fb_rd = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.resp_load = 1'b1;
          clr_resp_d      = 1'b0;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // reset starts with a full white sweep of the frame store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_resp_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_resp_q <= clr_resp_d;
    end
  end

endmodule

/* rtl/core/gbr_datapath.sv */
// Blitter datapath: font memory, frame store, address reduction, pixel mapping, result register.
module gbr_datapath #(
  parameter int DRIVER_COLUMNS  = 800,
  parameter int PANEL_ROWS      = 272,
  parameter int VISIBLE_COLUMNS = 792,
  parameter int FONT_BYTES      = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [9:0]    cfg_data_i,
  input  logic [1:0]    cmd_i,
  input  logic [12:0]   font_address_i,
  input  logic [7:0]    font_data_i,
  input  logic [14:0]   fb_address_i,
  input  logic [12:0]   bitmap_offset_i,
  input  logic [5:0]    glyph_width_i,
  input  logic [5:0]    glyph_height_i,
  input  logic [5:0]    x_offset_i,
  input  logic [6:0]    y_offset_i,
  input  logic [15:0]   cursor_x_i,
  input  logic [15:0]   baseline_y_i,
  input  gbr_pkg::ctl_t ctl_i,
  output gbr_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    read_data_o,
  output logic [1:0]    done_cmd_o
);

  function automatic int calc_red_steps(int depth);
    int n;
    n = 1;
    while ((depth << n) < (1 << gbr_pkg::FONT_ADDR_W)) n++;
    return n;
  endfunction

  localparam int ROW_BYTES = (DRIVER_COLUMNS + 7) / 8;
  localparam int FB_BYTES  = ROW_BYTES * PANEL_ROWS;
  localparam int FBA_W     = $clog2(FB_BYTES);
  localparam int FA_W      = $clog2(FONT_BYTES);
  localparam int SX_W      = $clog2(VISIBLE_COLUMNS + 64);
  localparam int DX_W      = $clog2(DRIVER_COLUMNS);
  localparam int Y_W       = $clog2(PANEL_ROWS);
  localparam int RED_STEPS = calc_red_steps(FONT_BYTES);
  localparam int RK_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int RED_W     = 18;

  // configuration
  logic [9:0] seam_x_q;
  logic [5:0] seam_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seam_x_q   <= gbr_pkg::SEAM_X_RST;
      seam_gap_q <= gbr_pkg::SEAM_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gbr_pkg::CFG_SEAM_X:   seam_x_q   <= cfg_data_i;
        gbr_pkg::CFG_SEAM_GAP: seam_gap_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // captured command
  gbr_pkg::cmd_e cmd_q;
  logic [7:0]    fdata_q;
  logic [5:0]    w_q, h_q;
  logic [16:0]   ox_q, oy_q;
  logic          rd_ok_q;
  logic          rd_ok;

  assign rd_ok = (32'(fb_address_i) < FB_BYTES);

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= gbr_pkg::cmd_e'(cmd_i);
      fdata_q <= font_data_i;
      w_q     <= glyph_width_i;
      h_q     <= glyph_height_i;
      ox_q    <= {cursor_x_i[15], cursor_x_i} + {{11{x_offset_i[5]}}, x_offset_i};
      oy_q    <= {baseline_y_i[15], baseline_y_i} + {{10{y_offset_i[6]}}, y_offset_i};
      rd_ok_q <= rd_ok;
    end
  end

  // font address reduction: one restoring compare-subtract per cycle
  logic [12:0]      red_q;
  logic [RK_W-1:0]  red_k_q;
  logic [RED_W-1:0] mod_sh;

  assign mod_sh = RED_W'(FONT_BYTES) << red_k_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      red_q   <= (gbr_pkg::cmd_e'(cmd_i) == gbr_pkg::CMD_LOAD) ? font_address_i
                                                                : bitmap_offset_i;
      red_k_q <= RK_W'(RED_STEPS - 1);
    end else if (ctl_i.red_step) begin
      if ({{(RED_W - 13){1'b0}}, red_q} >= mod_sh) begin
        red_q <= red_q - mod_sh[12:0];
      end
      red_k_q <= red_k_q - 1'b1;
    end
  end

  // glyph walk
  logic [5:0]      col_q, row_q;
  logic [2:0]      bit_q;
  logic [FA_W-1:0] fptr_q;
  logic [7:0]      font_q;
  logic            col_last, row_last;

  assign col_last = (col_q == w_q - 6'd1);
  assign row_last = (row_q == h_q - 6'd1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.draw_init) begin
      col_q  <= '0;
      row_q  <= '0;
      bit_q  <= '0;
      fptr_q <= FA_W'(red_q);
    end else if (ctl_i.advance) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_q + 6'd1;
      end else begin
        col_q <= col_q + 6'd1;
      end
      bit_q <= bit_q + 3'd1;
      if (bit_q == 3'd7) begin
        fptr_q <= (fptr_q == FA_W'(FONT_BYTES - 1)) ? '0 : fptr_q + 1'b1;
      end
    end
  end

  logic [7:0] font_mem [FONT_BYTES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.font_wr) begin
      font_mem[FA_W'(red_q)] <= fdata_q;
    end
    if (ctl_i.font_rd) begin
      font_q <= font_mem[fptr_q];
    end
  end

  // pixel mapping, one step per cycle
  logic signed [17:0] px_q, py_q;
  logic [SX_W-1:0]    sx_q;
  logic [Y_W-1:0]     y_q, dy_q;
  logic [DX_W-1:0]    dx_q;
  logic               vis_q, ok_q;
  logic [FBA_W-1:0]   fb_addr_q;
  logic [7:0]         mask_q;
  logic               vis, seam_hit;

  assign vis = !px_q[17] && (px_q[16:0] < 17'(VISIBLE_COLUMNS)) &&
               !py_q[17] && (py_q[16:0] < 17'(PANEL_ROWS));
  assign seam_hit = (px_q[16:0] >= {7'd0, seam_x_q});

  always_ff @(posedge clk_i) begin
    if (ctl_i.pix_load) begin
      px_q <= {ox_q[16], ox_q} + {12'd0, col_q};
      py_q <= {oy_q[16], oy_q} + {12'd0, row_q};
    end
    if (ctl_i.pix_map) begin
      vis_q <= vis;
      sx_q  <= SX_W'(px_q[16:0]) + (seam_hit ? SX_W'(seam_gap_q) : '0);
      y_q   <= Y_W'(py_q[16:0]);
    end
    if (ctl_i.pix_mirror) begin
      ok_q <= vis_q && (int'(sx_q) < DRIVER_COLUMNS);
      dx_q <= DX_W'(DRIVER_COLUMNS - 1 - int'(sx_q));
      dy_q <= Y_W'(PANEL_ROWS - 1 - int'(y_q));
    end
    if (ctl_i.capture) begin
      fb_addr_q <= rd_ok ? FBA_W'(fb_address_i) : '0;
    end else if (ctl_i.pix_addr) begin
      fb_addr_q <= FBA_W'(int'(dy_q) * ROW_BYTES + int'(dx_q >> 3));
      mask_q    <= gbr_pkg::MSB_MASK >> dx_q[2:0];
    end
  end

  // frame store
  logic [FBA_W-1:0] clr_addr_q;
  logic [7:0]       fb_q;
  logic [7:0]       fb_mem [FB_BYTES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (ctl_i.clr_step) begin
      clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_step) begin
      fb_mem[clr_addr_q] <= gbr_pkg::WHITE_BYTE;
    end else if (ctl_i.fb_wr) begin
      fb_mem[fb_addr_q] <= fb_q & ~mask_q;
    end
    if (ctl_i.fb_rd) begin
      fb_q <= fb_mem[fb_addr_q];
    end
  end

  // result register
  logic       out_valid_q;
  logic [7:0] read_data_q;
  logic [1:0] done_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.resp_load) begin
      read_data_q <= (cmd_q == gbr_pkg::CMD_READ && rd_ok_q) ? fb_q : 8'd0;
      done_cmd_q  <= cmd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign done_cmd_o  = done_cmd_q;

  always_comb begin
    sts_o            = '0;
    sts_o.cmd        = cmd_q;
    sts_o.clr_last   = (clr_addr_q == FBA_W'(FB_BYTES - 1));
    sts_o.red_last   = (red_k_q == '0);
    sts_o.draw_empty = (w_q == 6'd0) || (h_q == 6'd0);
    sts_o.bit_set    = font_q[3'd7 - bit_q];
    sts_o.pix_ok     = ok_q;
    sts_o.draw_last  = col_last && row_last;
    sts_o.byte_next  = (bit_q == 3'd7);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

/* rtl/core/glyph_blitter_rotated_framebuffer.sv */
// Load and draw first reduce the font address by restoring compare-subtract steps; load then
// writes the font byte, read fetches a frame store byte, clear sweeps the store. Draw walks the
// glyph bit by bit, fetching a font byte per eight bits; set bits on the panel are painted.
// One command in flight; the result register lets the next command start while a result waits.
// Reset: seam_x 396, seam_gap 8; the frame store is swept to white, one byte per cycle
// (FB_BYTES bytes, 27200 by default), with in_ready_o low until the sweep ends.
module glyph_blitter_rotated_framebuffer #(
  parameter int DRIVER_COLUMNS  = 800,
  parameter int PANEL_ROWS      = 272,
  parameter int VISIBLE_COLUMNS = 792,
  parameter int FONT_BYTES      = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [12:0] font_address_i,
  input  logic [7:0]  font_data_i,
  input  logic [14:0] fb_address_i,
  input  logic [12:0] bitmap_offset_i,
  input  logic [5:0]  glyph_width_i,
  input  logic [5:0]  glyph_height_i,
  input  logic [5:0]  x_offset_i,
  input  logic [6:0]  y_offset_i,
  input  logic [15:0] cursor_x_i,
  input  logic [15:0] baseline_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [1:0]  done_cmd_o
);

  gbr_pkg::ctl_t ctl;
  gbr_pkg::sts_t sts;

  gbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  gbr_datapath #(
    .DRIVER_COLUMNS  (DRIVER_COLUMNS),
    .PANEL_ROWS      (PANEL_ROWS),
    .VISIBLE_COLUMNS (VISIBLE_COLUMNS),
    .FONT_BYTES      (FONT_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd_i),
    .font_address_i  (font_address_i),
    .font_data_i     (font_data_i),
    .fb_address_i    (fb_address_i),
    .bitmap_offset_i (bitmap_offset_i),
    .glyph_width_i   (glyph_width_i),
    .glyph_height_i  (glyph_height_i),
    .x_offset_i      (x_offset_i),
    .y_offset_i      (y_offset_i),
    .cursor_x_i      (cursor_x_i),
    .baseline_y_i    (baseline_y_i),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .done_cmd_o      (done_cmd_o)
  );

  // only a read beat carries a nonzero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (done_cmd_o != gbr_pkg::CMD_READ) |-> (read_data_o == 8'd0))
    else $error("nonzero read_data on a non-read result");

  // one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken while one is in flight");

  // no frame store or font memory write while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ctl.fb_wr && !ctl.clr_step && !ctl.font_wr)
    else $error("memory write while idle");

  // a result is loaded only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.resp_load |-> (!out_valid_o || out_ready_i))
    else $error("result overwrote a pending beat");

endmodule
